@@ sv/nwc_pkg.sv @@
`timescale 1ns / 1ps
// nwc_pkg: shared types, constants and the weight lookup of the
// normalized window convolution core; no dependencies

package nwc_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_KERNEL = 3;
    localparam int TAPS           = 9;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_KERNEL_SIZE   = 3'd1,
        REG_KERNEL_TOP    = 3'd2,
        REG_KERNEL_MIDDLE = 3'd3,
        REG_KERNEL_BOTTOM = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] pixel_blue;
        logic [7:0] pixel_green;
        logic [7:0] pixel_red;
    } pixel_in_t;

    typedef struct packed {
        logic       zero_weight;
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
    } pixel_out_t;

    // tap t: row offset t/3 (0 = current row), column offset t%3
    typedef struct packed {
        logic [TAPS-1:0][23:0] pix;
        logic [TAPS-1:0]       mask;
    } work_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic signed [7:0] tap_weight(
        input logic [23:0] row_top,
        input logic [23:0] row_mid,
        input logic [23:0] row_bot,
        input logic [3:0]  tap
    );
        logic signed [7:0] w;
        w = '0;
        case (tap)
            4'd0: w = row_bot[23:16];
            4'd1: w = row_bot[15:8];
            4'd2: w = row_bot[7:0];
            4'd3: w = row_mid[23:16];
            4'd4: w = row_mid[15:8];
            4'd5: w = row_mid[7:0];
            4'd6: w = row_top[23:16];
            4'd7: w = row_top[15:8];
            4'd8: w = row_top[7:0];
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

@@ sv/nwc_queue.sv @@
`timescale 1ns / 1ps
// nwc_queue: two-entry queue of window items between front and back
// depends on nwc_pkg

module nwc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  nwc_pkg::work_item_t push_item,
    input  logic                pop,
    output nwc_pkg::work_item_t head_item,
    output nwc_pkg::queue_status_t status
);
    import nwc_pkg::*;

    work_item_t entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item    = entry_reg[rd_ptr_reg];
    assign status.full  = count_reg == 2'(QUEUE_DEPTH);
    assign status.empty = count_reg == 2'd0;

endmodule

@@ sv/nwc_front.sv @@
`timescale 1ns / 1ps
// nwc_front: pixel intake, raster position, line store and window columns
// builds one masked 3x3 window item per pixel; depends on nwc_pkg

module nwc_front #(
    parameter int MAX_WIDTH  = nwc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = nwc_pkg::DEF_MAX_KERNEL
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  nwc_pkg::pixel_in_t     in_data,
    input  logic [10:0]            image_width,
    input  logic [1:0]             kernel_size,
    input  nwc_pkg::queue_status_t q_status,
    output logic                   push,
    output nwc_pkg::work_item_t    push_item
);
    import nwc_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int CW = (XW + 1 > 11) ? XW + 2 : 12;

    typedef enum logic {F_IDLE, F_BUILD} fstate_t;

    fstate_t      state_reg;
    logic [XW-1:0] col_reg;
    logic [1:0]   rows_reg;
    logic [23:0]  pix_reg;
    logic [47:0]  rd_reg;
    logic [23:0]  win_reg [3][2];
    logic [47:0]  line_mem [MAX_WIDTH];

    logic          accept;
    logic [XW-1:0] col_cur;
    logic [1:0]    rows_cur;
    logic [CW-1:0] w_ext, w_eff, col_inc;
    logic [1:0]    ks_eff;
    logic          row_end;
    logic [23:0]   column [3];

    always_comb
    begin
        accept   = in_valid && !in_stall;
        col_cur  = in_data.frame_start ? '0 : col_reg;
        rows_cur = in_data.frame_start ? '0 : rows_reg;
        w_ext    = CW'(image_width);
        if (w_ext == '0)
            w_eff = CW'(1);
        else if (w_ext > CW'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = w_ext;
        col_inc = CW'(col_reg) + CW'(1);
        row_end = col_inc >= w_eff;
        if (kernel_size == 2'd0)
            ks_eff = 2'd1;
        else if (kernel_size > 2'(MAX_KERNEL))
            ks_eff = 2'(MAX_KERNEL);
        else
            ks_eff = kernel_size;
        column[0] = pix_reg;
        column[1] = rd_reg[23:0];
        column[2] = rd_reg[47:24];
        for (int t = 0; t < TAPS; t++)
        begin
            push_item.pix[t]  = (t % 3 == 0) ? column[t / 3]
                              : win_reg[t / 3][(t % 3 == 0) ? 0 : t % 3 - 1];
            push_item.mask[t] = (2'(t / 3) < ks_eff) && (2'(t % 3) < ks_eff)
                             && (2'(t / 3) <= rows_reg) && (XW'(t % 3) <= col_reg);
        end
    end

    assign in_stall = state_reg == F_BUILD;
    assign push     = state_reg == F_BUILD && !q_status.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            rows_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        col_reg   <= col_cur;
                        rows_reg  <= rows_cur;
                        state_reg <= F_BUILD;
                    end
                end
                F_BUILD:
                begin
                    if (push)
                    begin
                        state_reg <= F_IDLE;
                        if (row_end)
                        begin
                            col_reg <= '0;
                            if (rows_reg < 2'(MAX_KERNEL - 1))
                                rows_reg <= rows_reg + 2'd1;
                        end
                        else
                        begin
                            col_reg <= col_inc[XW-1:0];
                        end
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    // line store: low half one row above, high half two rows above
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= {in_data.pixel_blue, in_data.pixel_green, in_data.pixel_red};
            rd_reg  <= line_mem[col_cur];
        end
        if (push)
        begin
            line_mem[col_reg] <= {rd_reg[23:0], pix_reg};
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][1] <= win_reg[r][0];
                win_reg[r][0] <= column[r];
            end
        end
    end

endmodule

@@ sv/nwc_back.sv @@
`timescale 1ns / 1ps
// nwc_back: tap-serial multiply-accumulate, bit-serial division, clamp
// and output register; depends on nwc_pkg

module nwc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  nwc_pkg::work_item_t    head_item,
    input  nwc_pkg::queue_status_t q_status,
    output logic                   pop,
    input  logic [23:0]            kernel_row_top,
    input  logic [23:0]            kernel_row_middle,
    input  logic [23:0]            kernel_row_bottom,
    output logic                   out_valid,
    input  logic                   out_stall,
    output nwc_pkg::pixel_out_t    out_data
);
    import nwc_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_MAC, B_ABS, B_DIV, B_FIN} bstate_t;

    bstate_t            state_reg;
    work_item_t         item_reg;
    logic [3:0]         tap_reg;
    logic [4:0]         cnt_reg;
    logic signed [20:0] sum_reg [3];
    logic signed [11:0] wsum_reg;
    logic [19:0]        num_reg [3];
    logic [10:0]        rem_reg [3];
    logic [10:0]        den_reg;
    logic [2:0]         neg_reg;
    logic               zero_reg;
    logic               out_valid_reg;
    pixel_out_t         out_reg;

    logic signed [7:0]  w;
    logic signed [16:0] prod [3];
    logic [11:0]        rem_sh [3];
    logic [7:0]         res [3];

    always_comb
    begin
        w = tap_weight(kernel_row_top, kernel_row_middle, kernel_row_bottom, tap_reg);
        for (int c = 0; c < 3; c++)
        begin
            prod[c]   = $signed({1'b0, item_reg.pix[tap_reg][8*c +: 8]}) * w;
            rem_sh[c] = {rem_reg[c], num_reg[c][19]};
            if (zero_reg || neg_reg[c])
                res[c] = '0;
            else if (|num_reg[c][19:8])
                res[c] = 8'hFF;
            else
                res[c] = num_reg[c][7:0];
        end
    end

    assign pop       = state_reg == B_IDLE && !q_status.empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_stall && state_reg != B_FIN)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        item_reg  <= head_item;
                        tap_reg   <= '0;
                        wsum_reg  <= '0;
                        for (int c = 0; c < 3; c++)
                            sum_reg[c] <= '0;
                        state_reg <= B_MAC;
                    end
                end
                B_MAC:
                begin
                    if (item_reg.mask[tap_reg])
                    begin
                        wsum_reg <= wsum_reg + 12'(w);
                        for (int c = 0; c < 3; c++)
                            sum_reg[c] <= sum_reg[c] + 21'(prod[c]);
                    end
                    tap_reg <= tap_reg + 4'd1;
                    if (tap_reg == 4'(TAPS - 1))
                        state_reg <= B_ABS;
                end
                B_ABS:
                begin
                    den_reg  <= wsum_reg[11] ? 11'(-wsum_reg) : 11'(wsum_reg);
                    zero_reg <= wsum_reg == '0;
                    cnt_reg  <= '0;
                    for (int c = 0; c < 3; c++)
                    begin
                        neg_reg[c] <= sum_reg[c][20] ^ wsum_reg[11];
                        num_reg[c] <= sum_reg[c][20] ? 20'(-sum_reg[c]) : 20'(sum_reg[c]);
                        rem_reg[c] <= '0;
                    end
                    state_reg <= (wsum_reg == '0) ? B_FIN : B_DIV;
                end
                B_DIV:
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        if (rem_sh[c] >= {1'b0, den_reg})
                        begin
                            rem_reg[c] <= 11'(rem_sh[c] - {1'b0, den_reg});
                            num_reg[c] <= {num_reg[c][18:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg[c] <= rem_sh[c][10:0];
                            num_reg[c] <= {num_reg[c][18:0], 1'b0};
                        end
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd19)
                        state_reg <= B_FIN;
                end
                B_FIN:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_reg.out_red     <= res[0];
                        out_reg.out_green   <= res[1];
                        out_reg.out_blue    <= res[2];
                        out_reg.zero_weight <= zero_reg;
                        out_valid_reg       <= 1'b1;
                        state_reg           <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

@@ sv/normalized_window_convolution_core.sv @@
`timescale 1ns / 1ps
// normalized_window_convolution_core: top level with configuration registers
// path: front window build, queue, tap accumulation, magnitudes, division
// (skipped on zero weight sum), output register; throughput is bound by the
// back end tap accumulator and divider; the front queues pixels meanwhile
// reset: asynchronous active low; clears position, row count, queue and
// handshakes; line store contents stay undefined and are masked by row count
module normalized_window_convolution_core #(
    parameter int MAX_WIDTH  = nwc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = nwc_pkg::DEF_MAX_KERNEL
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  nwc_pkg::pixel_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output nwc_pkg::pixel_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data
);
    import nwc_pkg::*;

    logic [10:0] image_width_reg;
    logic [1:0]  kernel_size_reg;
    logic [23:0] kernel_top_reg;
    logic [23:0] kernel_mid_reg;
    logic [23:0] kernel_bot_reg;

    queue_status_t q_status;
    work_item_t    push_item;
    work_item_t    head_item;
    logic          push;
    logic          pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= 11'd1024;
            kernel_size_reg <= 2'd3;
            kernel_top_reg  <= 24'h010101;
            kernel_mid_reg  <= 24'h010101;
            kernel_bot_reg  <= 24'h010101;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:   image_width_reg <= cfg_data[10:0];
                REG_KERNEL_SIZE:   kernel_size_reg <= cfg_data[1:0];
                REG_KERNEL_TOP:    kernel_top_reg  <= cfg_data;
                REG_KERNEL_MIDDLE: kernel_mid_reg  <= cfg_data;
                REG_KERNEL_BOTTOM: kernel_bot_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    nwc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .image_width (image_width_reg),
        .kernel_size (kernel_size_reg),
        .q_status    (q_status),
        .push        (push),
        .push_item   (push_item)
    );

    nwc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    nwc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head_item         (head_item),
        .q_status          (q_status),
        .pop               (pop),
        .kernel_row_top    (kernel_top_reg),
        .kernel_row_middle (kernel_mid_reg),
        .kernel_row_bottom (kernel_bot_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_data          (out_data)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.zero_weight) |->
        (out_data.out_red == 8'd0 && out_data.out_green == 8'd0
         && out_data.out_blue == 8'd0))
        else $error("zero weight result with nonzero color");

endmodule
